### rtl/core/barometric_pressure_compensation_defines.svh
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BPC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bpc_pkg.sv
package bpc_pkg;

  localparam int RAW_W      = 24;
  localparam int COEFF_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_W      = 32;
  localparam int IN_DATA_W  = 2 * RAW_W;
  localparam int OUT_DATA_W = 2 * OUT_W;

  localparam int DT_W      = RAW_W + 1;
  localparam int PROD_W    = DT_W + COEFF_W + 1;
  localparam int DSQ_W     = 2 * DT_W;
  localparam int Q_W       = 19;
  localparam int TEMP_W    = 20;
  localparam int TCORR_W   = 17;
  localparam int SQ_W      = 36;
  localparam int CORR_W    = 42;
  localparam int OFF_W     = 44;
  localparam int SENS_W    = 40;
  localparam int SENS_LO_W = 20;
  localparam int MUL_W     = 46;
  localparam int FULL_W    = 66;
  localparam int X_W       = 44;
  localparam int Y_W       = 46;

  localparam int REF_SHIFT       = 8;
  localparam int T_SHIFT         = 23;
  localparam int OFF_SHIFT       = 6;
  localparam int SENS_SHIFT      = 7;
  localparam int OFF_BASE_SHIFT  = 17;
  localparam int SENS_BASE_SHIFT = 16;
  localparam int TCORR_LSB       = 31;
  localparam int CORR_SHIFT      = 4;
  localparam int PRESS_SHIFT     = 21;
  localparam int OUT_SHIFT       = 15;

  localparam int TEMP_REF    = 2000;
  localparam int COLD_LIMIT  = -1500;
  localparam int COLD_BIAS   = 3500;
  localparam int OFF2_WARM   = 61;
  localparam int OFF2_COLD   = 15;
  localparam int SENS2_WARM  = 2;
  localparam int SENS2_COLD  = 8;

  localparam int PIPE_DEPTH = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS       = 3'd0,
    REG_OFFSET     = 3'd1,
    REG_SENS_TEMP  = 3'd2,
    REG_OFF_TEMP   = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_SENS  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [COEFF_W-1:0] sens_coeff;
    logic [COEFF_W-1:0] offset_coeff;
    logic [COEFF_W-1:0] sens_temp_coeff;
    logic [COEFF_W-1:0] offset_temp_coeff;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_sens_coeff;
  } coeff_t;

  typedef struct packed {
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [Q_W-1:0]    dtemp;
    logic signed [TEMP_W-1:0] temp1;
    logic [TCORR_W-1:0]       tcorr;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } front_t;

  typedef struct packed {
    logic [RAW_W-1:0]         raw_pressure;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } corr_t;

endpackage

### rtl/core/bpc_front.sv
module bpc_front
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  coeff_t           coeff,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  output logic             out_valid,
  input  logic             out_ready,
  output front_t           out
);

  logic [2:0] v;
  logic [2:0] en;

  logic [RAW_W-1:0]          a_d1;
  logic signed [DT_W-1:0]    a_dt;
  logic [RAW_W-1:0]          b_d1;
  logic signed [PROD_W-1:0]  b_p6;
  logic signed [PROD_W-1:0]  b_p4;
  logic signed [PROD_W-1:0]  b_p3;
  logic signed [DSQ_W-1:0]   b_pdd;
  front_t                    c;

  logic signed [DT_W-1:0]    dt_next;
  logic signed [PROD_W-1:0]  p6_adj;
  logic signed [PROD_W-1:0]  p4_adj;
  logic signed [PROD_W-1:0]  p3_adj;
  logic signed [PROD_W-1:0]  p6_q;
  logic signed [PROD_W-1:0]  p4_q;
  logic signed [PROD_W-1:0]  p3_q;
  logic signed [Q_W-1:0]     q_next;
  front_t                    c_next;

  always_comb begin
    en[2]    = !v[2] || out_ready;
    en[1]    = !v[1] || en[2];
    en[0]    = !v[0] || en[1];
    in_ready = en[0] && !rst;
  end

  assign dt_next = $signed({1'b0, raw_temperature})
                 - $signed({1'b0, coeff.ref_temp, {REF_SHIFT{1'b0}}});

  always_comb begin
    p6_adj = b_p6 + $signed({{(PROD_W-T_SHIFT){1'b0}}, {T_SHIFT{b_p6[PROD_W-1]}}});
    p4_adj = b_p4 + $signed({{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{b_p4[PROD_W-1]}}});
    p3_adj = b_p3 + $signed({{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{b_p3[PROD_W-1]}}});
    p6_q   = p6_adj >>> T_SHIFT;
    p4_q   = p4_adj >>> OFF_SHIFT;
    p3_q   = p3_adj >>> SENS_SHIFT;
    q_next = p6_q[Q_W-1:0];
    c_next.raw_pressure = b_d1;
    c_next.dtemp        = q_next;
    c_next.temp1        = TEMP_W'(TEMP_REF) + TEMP_W'(q_next);
    c_next.tcorr        = b_pdd[TCORR_LSB +: TCORR_W];
    c_next.off          = $signed(OFF_W'({coeff.offset_coeff, {OFF_BASE_SHIFT{1'b0}}}))
                        + OFF_W'(p4_q);
    c_next.sens         = $signed(SENS_W'({coeff.sens_coeff, {SENS_BASE_SHIFT{1'b0}}}))
                        + SENS_W'(p3_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid && in_ready;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_d1 <= raw_pressure;
      a_dt <= dt_next;
    end
    if (en[1]) begin
      b_d1  <= a_d1;
      b_p6  <= a_dt * $signed({1'b0, coeff.temp_sens_coeff});
      b_p4  <= a_dt * $signed({1'b0, coeff.offset_temp_coeff});
      b_p3  <= a_dt * $signed({1'b0, coeff.sens_temp_coeff});
      b_pdd <= a_dt * a_dt;
    end
    if (en[2]) begin
      c <= c_next;
    end
  end

  assign out_valid = v[2];
  assign out       = c;

endmodule

### rtl/core/bpc_corr.sv
module bpc_corr
  import bpc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in,
  output logic   out_valid,
  input  logic   out_ready,
  output corr_t  out
);

  logic [2:0] v;
  logic [2:0] en;

  logic [RAW_W-1:0]         d_d1;
  logic signed [TEMP_W-1:0] d_temp1;
  logic [TCORR_W-1:0]       d_tcorr;
  logic signed [OFF_W-1:0]  d_off;
  logic signed [SENS_W-1:0] d_sens;
  logic [SQ_W-1:0]          d_sqw;
  logic [SQ_W-1:0]          d_sqc;
  logic                     d_warm;
  logic                     d_cold;

  logic [RAW_W-1:0]         e_d1;
  logic signed [TEMP_W-1:0] e_temp;
  logic signed [OFF_W-1:0]  e_off;
  logic signed [SENS_W-1:0] e_sens;
  logic [CORR_W-1:0]        e_offc;
  logic [CORR_W-1:0]        e_sensc;

  corr_t                    f;

  logic signed [Q_W-1:0]    cold;
  logic signed [2*Q_W-1:0]  sqw_full;
  logic signed [2*Q_W-1:0]  sqc_full;
  logic [CORR_W-1:0]        sqw_x;
  logic [CORR_W-1:0]        sqc_x;
  logic [CORR_W-1:0]        offc_warm;
  logic [CORR_W-1:0]        offc_cold;
  logic [CORR_W-1:0]        sensc_warm;
  logic [CORR_W-1:0]        sensc_cold;

  always_comb begin
    en[2]    = !v[2] || out_ready;
    en[1]    = !v[1] || en[2];
    en[0]    = !v[0] || en[1];
    in_ready = en[0];
  end

  always_comb begin
    cold     = in.dtemp + Q_W'(COLD_BIAS);
    sqw_full = in.dtemp * in.dtemp;
    sqc_full = cold * cold;
  end

  always_comb begin
    sqw_x      = CORR_W'(d_sqw);
    sqc_x      = CORR_W'(d_sqc);
    offc_warm  = d_warm ? ((sqw_x * CORR_W'(OFF2_WARM)) >> CORR_SHIFT) : '0;
    offc_cold  = d_cold ? (sqc_x * CORR_W'(OFF2_COLD)) : '0;
    sensc_warm = d_warm ? (sqw_x * CORR_W'(SENS2_WARM)) : '0;
    sensc_cold = d_cold ? (sqc_x * CORR_W'(SENS2_COLD)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_d1    <= in.raw_pressure;
      d_temp1 <= in.temp1;
      d_tcorr <= in.tcorr;
      d_off   <= in.off;
      d_sens  <= in.sens;
      d_sqw   <= sqw_full[SQ_W-1:0];
      d_sqc   <= sqc_full[SQ_W-1:0];
      d_warm  <= in.dtemp[Q_W-1];
      d_cold  <= in.temp1 < TEMP_W'(COLD_LIMIT);
    end
    if (en[1]) begin
      e_d1    <= d_d1;
      e_temp  <= d_temp1 - $signed(d_warm ? TEMP_W'(d_tcorr) : TEMP_W'(0));
      e_off   <= d_off;
      e_sens  <= d_sens;
      e_offc  <= offc_warm + offc_cold;
      e_sensc <= sensc_warm + sensc_cold;
    end
    if (en[2]) begin
      f.raw_pressure <= e_d1;
      f.temp         <= e_temp;
      f.off          <= e_off - $signed(OFF_W'(e_offc));
      f.sens         <= e_sens - $signed(SENS_W'(e_sensc));
    end
  end

  assign out_valid = v[2];
  assign out       = f;

endmodule

### rtl/core/bpc_press.sv
module bpc_press
  import bpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  corr_t                   in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] pressure_pa,
  output logic signed [OUT_W-1:0] temperature_centideg
);

  logic [2:0] v;
  logic [2:0] en;

  logic signed [MUL_W-1:0]  g_plo;
  logic signed [MUL_W-1:0]  g_phi;
  logic signed [OFF_W-1:0]  g_off;
  logic signed [TEMP_W-1:0] g_temp;

  logic signed [X_W-1:0]    h_x;
  logic signed [OFF_W-1:0]  h_off;
  logic signed [TEMP_W-1:0] h_temp;

  logic signed [OUT_W-1:0]  i_press;
  logic signed [OUT_W-1:0]  i_temp;

  logic signed [RAW_W:0]    d1s;
  logic signed [FULL_W-1:0] prod;
  logic signed [FULL_W-1:0] prod_adj;
  logic signed [FULL_W-1:0] prod_q;
  logic signed [Y_W-1:0]    y;
  logic signed [Y_W-1:0]    y_adj;
  logic signed [Y_W-1:0]    y_q;

  always_comb begin
    en[2]    = !v[2] || out_ready;
    en[1]    = !v[1] || en[2];
    en[0]    = !v[0] || en[1];
    in_ready = en[0];
  end

  assign d1s = $signed({1'b0, in.raw_pressure});

  always_comb begin
    prod     = ($signed(FULL_W'(g_phi)) <<< SENS_LO_W) + FULL_W'(g_plo);
    prod_adj = prod + $signed({{(FULL_W-PRESS_SHIFT){1'b0}},
                               {PRESS_SHIFT{prod[FULL_W-1]}}});
    prod_q   = prod_adj >>> PRESS_SHIFT;
    y        = Y_W'(h_x) - Y_W'(h_off);
    y_adj    = y + $signed({{(Y_W-OUT_SHIFT){1'b0}}, {OUT_SHIFT{y[Y_W-1]}}});
    y_q      = y_adj >>> OUT_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      g_plo  <= d1s * $signed({1'b0, in.sens[SENS_LO_W-1:0]});
      g_phi  <= d1s * $signed(in.sens[SENS_W-1:SENS_LO_W]);
      g_off  <= in.off;
      g_temp <= in.temp;
    end
    if (en[1]) begin
      h_x    <= prod_q[X_W-1:0];
      h_off  <= g_off;
      h_temp <= g_temp;
    end
    if (en[2]) begin
      i_press <= y_q[OUT_W-1:0];
      i_temp  <= OUT_W'(h_temp);
    end
  end

  assign out_valid            = v[2];
  assign pressure_pa          = i_press;
  assign temperature_centideg = i_temp;

endmodule

### rtl/core/barometric_pressure_compensation.sv
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tdata: raw_pressure, raw_temperature
// m_*       out        m_tvalid / m_tready       m_tdata: pressure_pa, temperature_centideg
// cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data (16-bit coefficient)
//
// One request per cycle sustained while m_tready is high; data passes through nine register stages
// (three in each of the front, correction and pressure units).
// The last stage is the output register, so earlier stages keep filling while a result waits.
// Each stage advances when it is empty or the stage after it advances; a stall holds full stages up to the first gap.
// Reset clears all stage valid bits and the six coefficients; no request is taken during reset.
module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // raw_pressure [23:0], raw_temperature [47:24]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pressure_pa [31:0], temperature_centideg [63:32]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEFF_W-1:0]    cfg_data
);

  coeff_t coeff;

  logic   front_valid;
  logic   front_ready;
  front_t front_out;
  logic   corr_valid;
  logic   corr_ready;
  corr_t  corr_out;

  logic signed [OUT_W-1:0] pressure_pa;
  logic signed [OUT_W-1:0] temperature_centideg;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_SENS:      coeff.sens_coeff        <= cfg_data;
        REG_OFFSET:    coeff.offset_coeff      <= cfg_data;
        REG_SENS_TEMP: coeff.sens_temp_coeff   <= cfg_data;
        REG_OFF_TEMP:  coeff.offset_temp_coeff <= cfg_data;
        REG_REF_TEMP:  coeff.ref_temp          <= cfg_data;
        REG_TEMP_SENS: coeff.temp_sens_coeff   <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .coeff           (coeff),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .raw_pressure    (s_tdata[RAW_W-1:0]),
    .raw_temperature (s_tdata[IN_DATA_W-1:RAW_W]),
    .out_valid       (front_valid),
    .out_ready       (front_ready),
    .out             (front_out)
  );

  bpc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in        (front_out),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out       (corr_out)
  );

  bpc_press u_press (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (corr_valid),
    .in_ready             (corr_ready),
    .in                   (corr_out),
    .out_valid            (m_tvalid),
    .out_ready            (m_tready),
    .pressure_pa          (pressure_pa),
    .temperature_centideg (temperature_centideg)
  );

  assign m_tdata = {temperature_centideg, pressure_pa};

endmodule

### rtl/core/bpc_checker.sv
`include "barometric_pressure_compensation_defines.svh"

module bpc_checker
  import bpc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] pending;
  logic [CNT_W-1:0] ready_run;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      ready_run <= '0;
    end else begin
      pending <= pending + CNT_W'(in_acc) - CNT_W'(out_acc);
      if (!m_tready) begin
        ready_run <= '0;
      end else if (ready_run != CNT_W'(PIPE_DEPTH)) begin
        ready_run <= ready_run + CNT_W'(1);
      end
    end
  end

  `BPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `BPC_ASSERT(a_no_orphan, m_tvalid, pending != '0, "result without a pending request")
  `BPC_ASSERT(a_depth_bound, 1'b1, pending <= CNT_W'(PIPE_DEPTH), "more requests in flight than stages")
  `BPC_ASSERT(a_latency, $past(in_acc, PIPE_DEPTH) && (ready_run >= CNT_W'(PIPE_DEPTH - 1)), m_tvalid, "result late with output ready")

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);
